// File: rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// Compare/capture timer package
// Shared types, register map and constants of the compare/capture timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

    localparam int unsigned CH_MAX           = 4;
    localparam int unsigned NUM_CHANNELS_DEF = 4;
    localparam int unsigned NUM_REGS         = 23;
    localparam int unsigned IDX_W            = 5;
    localparam int unsigned DATA_W           = 32;
    localparam int unsigned S_TDATA_W        = 40;
    localparam int unsigned M_TDATA_W        = 40;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [IDX_W-1:0] R_START     = 5'd0;
    localparam logic [IDX_W-1:0] R_STOP      = 5'd1;
    localparam logic [IDX_W-1:0] R_COUNT     = 5'd2;
    localparam logic [IDX_W-1:0] R_CLEAR     = 5'd3;
    localparam logic [IDX_W-1:0] R_CAPTURE0  = 5'd4;
    localparam logic [IDX_W-1:0] R_CAPTURE3  = 5'd7;
    localparam logic [IDX_W-1:0] R_EVENT0    = 5'd8;
    localparam logic [IDX_W-1:0] R_SHORTS    = 5'd12;
    localparam logic [IDX_W-1:0] R_INTSET    = 5'd13;
    localparam logic [IDX_W-1:0] R_INTCLR    = 5'd14;
    localparam logic [IDX_W-1:0] R_MODE      = 5'd15;
    localparam logic [IDX_W-1:0] R_BITMODE   = 5'd16;
    localparam logic [IDX_W-1:0] R_PRESCALER = 5'd17;
    localparam logic [IDX_W-1:0] R_CC0       = 5'd18;
    localparam logic [IDX_W-1:0] R_LAST      = 5'd22;

    localparam logic [DATA_W-1:0] MASK_16BIT    = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_8BIT     = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_24BIT    = 32'h00FF_FFFF;
    localparam logic [DATA_W-1:0] BITMODE_16    = 32'd0;
    localparam logic [DATA_W-1:0] BITMODE_8     = 32'd1;
    localparam logic [DATA_W-1:0] BITMODE_24    = 32'd2;
    localparam logic [DATA_W-1:0] MODE_COUNTER  = 32'd1;
    localparam logic [DATA_W-1:0] MAX_PRESCALER = 32'd9;
    localparam int unsigned       SHORT_STOP_OFS = 8;
    localparam int unsigned       INT_CMP_OFS    = 16;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pulse;
        logic              unsupported;
        logic [CH_MAX-1:0] compare_hits;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/compare_capture_timer_unit.sv
// ----------------------------------------------------------------------------
// Compare/capture timer unit
// Timer with compare/capture channels behind a register file, driven by a
// stream of register reads, register writes and prescaled ticks.
// ----------------------------------------------------------------------------
// Each beat on the s_ channel is one command: a register read, a register
// write or one prescaled tick, selected by s_tuser. Every command yields
// exactly one result beat on the m_ channel, carrying the read word, the
// interrupt pulse, the unsupported-write flag and the per-channel compare
// hits. A command is captured in an input register, evaluated combinationally
// by the engine and placed in the result register, from which it is offered
// on the m_ channel. One command per cycle is sustained while the receiver
// takes results; the engine's pass runs through the four chained channel
// compares. When the receiver stalls, the held result stays on
// m_tdata and the input register still takes one further command, after
// which s_tready falls until the result is taken. Reset clears both
// registers' valid flags, the count, the interrupt mask and the pending
// interrupt, and sets the register file to its idle state with the timer
// stopped.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_capture_timer_unit #(
    parameter int unsigned NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: reg_index [4:0], write_data [36:5], zero [39:37]
    input  wire logic [cct_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: action [1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata: read_data [31:0], irq_pulse [32], unsupported [33],
    // compare_hits [37:34], zero [39:38]
    output logic [cct_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cct_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    cct_engine #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.action     <= s_tuser;
            item_reg.reg_index  <= s_tdata[IDX_W-1:0];
            item_reg.write_data <= s_tdata[IDX_W+DATA_W-1:IDX_W];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, res_reg.compare_hits, res_reg.unsupported,
                       res_reg.irq_pulse, res_reg.read_data};

endmodule

`default_nettype wire

// File: rtl/cct_engine.sv
// ----------------------------------------------------------------------------
// Compare/capture timer engine
// Holds the register file, count, interrupt mask and pending flag, and works
// out the result and next state of one item in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_engine #(
    parameter int unsigned NUM_CHANNELS = cct_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire cct_pkg::item_t  item,
    output cct_pkg::result_t     result
);
    import cct_pkg::*;

    logic [DATA_W-1:0] regs_reg  [NUM_REGS];
    logic [DATA_W-1:0] regs_next [NUM_REGS];
    logic [DATA_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0] mask_reg, mask_next;
    logic              pending_reg, pending_next;

    always_comb begin
        logic [DATA_W-1:0] cnt;
        logic              stopped;
        logic              stop_hit;
        logic [IDX_W-1:0]  cc_idx;
        logic [IDX_W-1:0]  ev_idx;
        logic [IDX_W-1:0]  cap_ch;

        for (int r = 0; r < NUM_REGS; r++) begin
            regs_next[r] = regs_reg[r];
        end
        count_next   = count_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        result       = '0;
        cnt          = '0;
        stop_hit     = 1'b0;
        cc_idx       = '0;
        ev_idx       = '0;
        cap_ch       = '0;
        stopped      = (regs_reg[R_STOP] != '0) && (regs_reg[R_START] == '0);

        case (item.action)
            ACT_READ: begin
                if (item.reg_index <= R_LAST) begin
                    result.read_data = regs_reg[item.reg_index];
                end
            end
            ACT_WRITE: begin
                if (item.reg_index <= R_LAST) begin
                    regs_next[item.reg_index] = item.write_data;
                    if (item.reg_index == R_START) begin
                        if (item.write_data != '0) begin
                            regs_next[R_STOP] = '0;
                        end
                    end else if (item.reg_index == R_STOP) begin
                        if (item.write_data != '0) begin
                            regs_next[R_START] = '0;
                        end
                    end else if (item.reg_index == R_COUNT) begin
                        result.unsupported = 1'b1;
                    end else if (item.reg_index == R_CLEAR) begin
                        count_next = '0;
                    end else if (item.reg_index inside {[R_CAPTURE0:R_CAPTURE3]}) begin
                        cap_ch = item.reg_index - R_CAPTURE0;
                        if (32'(cap_ch) < NUM_CHANNELS) begin
                            regs_next[R_CC0 + cap_ch] = count_reg;
                        end
                    end else if (item.reg_index == R_INTSET) begin
                        mask_next = mask_reg | item.write_data;
                    end else if (item.reg_index == R_INTCLR) begin
                        mask_next = mask_reg & ~item.write_data;
                    end else if (item.reg_index == R_MODE) begin
                        result.unsupported = (item.write_data == MODE_COUNTER);
                    end else if (item.reg_index == R_PRESCALER) begin
                        result.unsupported = (item.write_data > MAX_PRESCALER);
                    end
                end
            end
            ACT_TICK: begin
                if (!stopped) begin
                    cnt = count_reg + 32'd1;
                    case (regs_reg[R_BITMODE])
                        BITMODE_16: cnt = cnt & MASK_16BIT;
                        BITMODE_8:  cnt = cnt & MASK_8BIT;
                        BITMODE_24: cnt = cnt & MASK_24BIT;
                        default:    cnt = cnt;
                    endcase
                    // Channels are evaluated in order; a short to clear
                    // changes what the later channels compare against.
                    for (int ch = 0; ch < CH_MAX; ch++) begin
                        cc_idx = R_CC0 + IDX_W'(ch);
                        ev_idx = R_EVENT0 + IDX_W'(ch);
                        if (ch < NUM_CHANNELS && !stop_hit && cnt == regs_reg[cc_idx]) begin
                            result.compare_hits[ch] = 1'b1;
                            regs_next[ev_idx]       = 32'd1;
                            if (regs_reg[R_SHORTS][ch]) begin
                                cnt = '0;
                            end
                            if (regs_reg[R_SHORTS][SHORT_STOP_OFS + ch]) begin
                                regs_next[R_STOP]  = 32'd1;
                                regs_next[R_START] = '0;
                                stop_hit           = 1'b1;
                            end else if (mask_reg[INT_CMP_OFS + ch]) begin
                                pending_next = 1'b1;
                            end
                        end
                    end
                    count_next = cnt;
                    if (!stop_hit && pending_next) begin
                        result.irq_pulse = 1'b1;
                        pending_next     = 1'b0;
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                regs_reg[r] <= (r == int'(R_STOP)) ? 32'd1 : 32'd0;
            end
            count_reg        <= '0;
            mask_reg         <= '0;
            pending_reg      <= 1'b0;
        end else if (advance) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                regs_reg[r] <= regs_next[r];
            end
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire
